/* hdl/lldr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lldr_pkg
// Shared types and constants for the low-level delayed relay.
// ----------------------------------------------------------------------------
package lldr_pkg;

  localparam int unsigned LevelW = 12;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Command codes carried by each input item
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_TRIP_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FAST_BLINK     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SLOW_BLINK     = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_ARM_DELAY      = 2'd3;

  // Register values after reset
  localparam logic [LevelW-1:0] TRIP_THRESHOLD_RST = 12'd3000;
  localparam logic [CountW-1:0] FAST_BLINK_RST     = 16'd200;
  localparam logic [CountW-1:0] SLOW_BLINK_RST     = 16'd1500;
  localparam logic [CountW-1:0] ARM_DELAY_RST      = 16'd4000;

  localparam logic [CountW-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [LevelW-1:0] trip_threshold;
    logic [CountW-1:0] fast_blink_ticks;
    logic [CountW-1:0] slow_blink_ticks;
    logic [CountW-1:0] arm_delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [CountW-1:0] blink_count;
    logic [CountW-1:0] delay_count;
    logic              below;
    logic              armed;
    logic              led;
    logic              relay;
  } state_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

/* hdl/lldr_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lldr_in_if / lldr_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface lldr_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [11:0] sample;

  modport source (output valid, command, sample, input ready);
  modport sink (input valid, command, sample, output ready);
endinterface

interface lldr_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] level;
  logic        indicator;
  logic        relay;
  logic        alarm_active;
  logic        relay_armed;

  modport source (output valid, level, indicator, relay, alarm_active, relay_armed,
                  input ready);
  modport sink (input valid, level, indicator, relay, alarm_active, relay_armed,
                output ready);
endinterface
`default_nettype wire

/* hdl/lldr_update.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lldr_update
// Next-state logic: applies one sample or one tick to the block state.
// ----------------------------------------------------------------------------
module lldr_update
  import lldr_pkg::*;
(
  input  var state_t             st,
  input  var cfg_t               cfg,
  input  var logic               command,
  input  var logic [LevelW-1:0]  sample,
  output state_t                 st_next
);

  logic [LevelW-1:0] lvl;
  logic [CountW-1:0] blink_inc;

  assign lvl       = {2'b00, sample[LevelW-1:2]} + st.level - {2'b00, st.level[LevelW-1:2]};
  assign blink_inc = sat_inc(st.blink_count);

  always_comb begin
    st_next = st;
    if (command == CMD_SAMPLE) begin
      st_next.level = lvl;
      if (lvl < cfg.trip_threshold) begin
        st_next.below = 1'b1;
      end else begin
        st_next.below       = 1'b0;
        st_next.delay_count = '0;
        st_next.armed       = 1'b0;
        st_next.relay       = 1'b0;
      end
    end else begin
      st_next.blink_count = blink_inc;
      if (st.below) begin
        if (blink_inc >= cfg.fast_blink_ticks) begin
          if (!st.armed) begin
            st_next.led = ~st.led;
          end
          st_next.blink_count = '0;
        end
        st_next.delay_count = sat_inc(st.delay_count);
        if (st.delay_count >= cfg.arm_delay_ticks && !st.armed) begin
          st_next.relay       = 1'b1;
          st_next.led         = 1'b0;
          st_next.delay_count = '0;
          st_next.armed       = 1'b1;
        end
      end else if (blink_inc >= cfg.slow_blink_ticks) begin
        st_next.led         = ~st.led;
        st_next.blink_count = '0;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/low_level_delayed_relay.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// low_level_delayed_relay
// Filtered level monitor that closes a relay after a delay below threshold.
// ----------------------------------------------------------------------------
// Each input item is a converter sample or a one millisecond tick; each item
// yields exactly one result item carrying the filtered level and the pin
// levels. The block takes one item per clock cycle while the output side is
// not stalled: an item is captured in an input register, the state update
// runs as short combinational logic (a 12-bit add/subtract and 16-bit
// compares), and the result lands in an output register. While a finished
// result waits in the output register, one more item can still be taken
// into the input register; that item then holds there, and the input side
// stalls, until the waiting result is taken. Configuration writes are
// applied at once and must only be made while the block is idle.
module low_level_delayed_relay
  import lldr_pkg::*;
(
  input  var logic                clk,
  input  var logic                rst,
  lldr_in_if.sink                 in_ch,
  lldr_out_if.source              out_ch,
  input  var logic                cfg_wr_en,
  input  var logic [CfgIdxW-1:0]  cfg_index,
  input  var logic [CfgDataW-1:0] cfg_data
);

  cfg_t              cfg;
  state_t            st;
  state_t            st_next;

  // Input register
  logic              in_valid;
  logic              in_command;
  logic [LevelW-1:0] in_sample;

  logic              advance;

  // Move the held item into the result register when there is room there
  assign advance      = in_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready  = !in_valid || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trip_threshold   <= TRIP_THRESHOLD_RST;
      cfg.fast_blink_ticks <= FAST_BLINK_RST;
      cfg.slow_blink_ticks <= SLOW_BLINK_RST;
      cfg.arm_delay_ticks  <= ARM_DELAY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TRIP_THRESHOLD: cfg.trip_threshold   <= cfg_data[LevelW-1:0];
        REG_FAST_BLINK:     cfg.fast_blink_ticks <= cfg_data[CountW-1:0];
        REG_SLOW_BLINK:     cfg.slow_blink_ticks <= cfg_data[CountW-1:0];
        REG_ARM_DELAY:      cfg.arm_delay_ticks  <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Capture an item whenever the input register is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_command <= in_ch.command;
      in_sample  <= in_ch.sample;
    end
  end

  lldr_update u_update (
    .st      (st),
    .cfg     (cfg),
    .command (in_command),
    .sample  (in_sample),
    .st_next (st_next)
  );

  // State advances once per item, in step with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.level        <= st_next.level;
      out_ch.indicator    <= st_next.led;
      out_ch.relay        <= st_next.relay;
      out_ch.alarm_active <= st_next.below;
      out_ch.relay_armed  <= st_next.armed;
    end
  end

endmodule
`default_nettype wire

/* hdl/lldr_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lldr_checker
// Port-level assertions for the low-level delayed relay, bound to the top.
// ----------------------------------------------------------------------------
module lldr_checker (
  input var logic        clk,
  input var logic        rst,
  input var logic        out_valid,
  input var logic        out_ready,
  input var logic [11:0] level,
  input var logic        indicator,
  input var logic        relay,
  input var logic        alarm_active,
  input var logic        relay_armed
);

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A waiting result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(level) && $stable(indicator) && $stable(relay) &&
      $stable(alarm_active) && $stable(relay_armed))
    else $error("result changed while stalled");

  // Armed and relay closed always travel together
  a_armed_relay: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> relay_armed == relay)
    else $error("relay state disagrees with armed flag");

  // Arming only happens while the level is below threshold
  a_armed_alarm: assert property (@(posedge clk) disable iff (rst)
    out_valid && relay_armed |-> alarm_active)
    else $error("armed without alarm");

endmodule

bind low_level_delayed_relay lldr_checker u_lldr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .level        (out_ch.level),
  .indicator    (out_ch.indicator),
  .relay        (out_ch.relay),
  .alarm_active (out_ch.alarm_active),
  .relay_armed  (out_ch.relay_armed)
);
`default_nettype wire

/* verif/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the low-level delayed relay: a cycle-free predictor
// tracks the filtered level, blink and arming counters for every accepted
// item and checks each returned status in order, over directed corner cases
// and randomised sample/tick bursts under several register settings.
// ----------------------------------------------------------------------------
module tb;
  import lldr_pkg::*;

  // No acceptance on either channel for this many cycles means a hang
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 140;

  // Status carried by one result item
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              indicator;
    logic              relay;
    logic              alarm_active;
    logic              relay_armed;
  } relay_status_t;

  // Predictor and in-order checker for the relay status stream
  class relay_tracker;
    cfg_t            regs;
    state_t          st;
    relay_status_t   pending_status[$];
    int unsigned     mismatches;

    function new();
      regs.trip_threshold   = TRIP_THRESHOLD_RST;
      regs.fast_blink_ticks = FAST_BLINK_RST;
      regs.slow_blink_ticks = SLOW_BLINK_RST;
      regs.arm_delay_ticks  = ARM_DELAY_RST;
      st = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_TRIP_THRESHOLD: regs.trip_threshold = data[LevelW-1:0];
        REG_FAST_BLINK:     regs.fast_blink_ticks = data;
        REG_SLOW_BLINK:     regs.slow_blink_ticks = data;
        REG_ARM_DELAY:      regs.arm_delay_ticks = data;
        default: ;
      endcase
    endfunction

    function logic [CountW-1:0] count_up(logic [CountW-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function int unsigned outstanding();
      return pending_status.size();
    endfunction

    // Advance the relay state by one item and queue the status it yields
    function void note_item(logic cmd, logic [LevelW-1:0] smp);
      logic [CountW-1:0] prev_delay;
      relay_status_t     s;
      if (cmd == CMD_SAMPLE) begin
        st.level = (smp >> 2) + st.level - (st.level >> 2);
        if (st.level < regs.trip_threshold) begin
          st.below = 1'b1;
        end else begin
          st.below = 1'b0;
          st.delay_count = '0;
          st.armed = 1'b0;
          st.relay = 1'b0;
        end
      end else begin
        st.blink_count = count_up(st.blink_count);
        if (st.below) begin
          if (st.blink_count >= regs.fast_blink_ticks) begin
            if (!st.armed) st.led = ~st.led;
            st.blink_count = '0;
          end
          prev_delay = st.delay_count;
          st.delay_count = count_up(st.delay_count);
          if (prev_delay >= regs.arm_delay_ticks && !st.armed) begin
            st.relay = 1'b1;
            st.led = 1'b0;
            st.delay_count = '0;
            st.armed = 1'b1;
          end
        end else if (st.blink_count >= regs.slow_blink_ticks) begin
          st.led = ~st.led;
          st.blink_count = '0;
        end
      end
      s.level = st.level;
      s.indicator = st.led;
      s.relay = st.relay;
      s.alarm_active = st.below;
      s.relay_armed = st.armed;
      pending_status.push_back(s);
    endfunction

    function string show(relay_status_t s);
      return $sformatf("level=%0d indicator=%0b relay=%0b alarm=%0b armed=%0b",
                       s.level, s.indicator, s.relay, s.alarm_active, s.relay_armed);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_status(relay_status_t got);
      relay_status_t want;
      if (pending_status.size() == 0) begin
        flag({"unexpected result: ", show(got)});
        return;
      end
      want = pending_status.pop_front();
      if (got.level != want.level || got.indicator != want.indicator ||
          got.relay != want.relay || got.alarm_active != want.alarm_active ||
          got.relay_armed != want.relay_armed)
        flag({"status mismatch: expected ", show(want), " got ", show(got)});
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = REG_TRIP_THRESHOLD;
  logic [CfgDataW-1:0] cfg_data = '0;

  lldr_in_if  in_ch();
  lldr_out_if out_ch();

  relay_tracker  tracker;
  relay_status_t seen_status;
  int unsigned   sent = 0;
  int unsigned   snd_idle_pct = 38;
  int unsigned   rcv_idle_pct = 56;
  int unsigned   idle_cycles = 0;

  low_level_delayed_relay dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: stall at random according to the current idling regime
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Result monitor: every item taken from the block is checked in order
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen_status.level = out_ch.level;
      seen_status.indicator = out_ch.indicator;
      seen_status.relay = out_ch.relay;
      seen_status.alarm_active = out_ch.alarm_active;
      seen_status.relay_armed = out_ch.relay_armed;
      tracker.check_status(seen_status);
    end
  end

  // Watchdog: count cycles in which neither channel moves an item
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("low_level_delayed_relay regression: fail");
      $finish;
    end
  end

  // Offer one item and hold it until the block takes it. Valid stays high
  // between back-to-back items so it is never dropped and raised in one step.
  task automatic send_item(input logic cmd, input logic [LevelW-1:0] smp);
    // Pick the idling regime: receiver-heavy, then sender-heavy, then none
    if (sent < 385) begin
      snd_idle_pct = 38;
      rcv_idle_pct = 56;
    end else if (sent < 770) begin
      snd_idle_pct = 56;
      rcv_idle_pct = 38;
    end else begin
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
    end
    if ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_item(cmd, smp);
    sent++;
  endtask

  // Drop valid, wait for every outstanding status, then let the two-stage
  // pipeline empty before anything touches the registers
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    tracker.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Write all four registers; the threshold word carries random upper bits,
  // which the block must ignore
  task automatic apply_settings(input cfg_t c);
    logic [CfgDataW-1:0] word;
    word = CfgDataW'($urandom);
    word[LevelW-1:0] = c.trip_threshold;
    load_reg(REG_TRIP_THRESHOLD, word);
    load_reg(REG_FAST_BLINK, c.fast_blink_ticks);
    load_reg(REG_SLOW_BLINK, c.slow_blink_ticks);
    load_reg(REG_ARM_DELAY, c.arm_delay_ticks);
    cfg_wr_en <= 1'b0;
  endtask

  // Register settings for each random phase: mostly short periods so that
  // blinking and arming happen often, plus both extremes
  function automatic cfg_t phase_settings(input int unsigned phase);
    cfg_t c;
    c.trip_threshold = LevelW'($urandom_range(4095));
    c.fast_blink_ticks = CountW'($urandom_range(1, 8));
    c.slow_blink_ticks = CountW'($urandom_range(1, 12));
    c.arm_delay_ticks = CountW'($urandom_range(40));
    case (phase)
      1: begin
        // Largest values: always triggered, never blinks, never arms
        c.trip_threshold = '1;
        c.fast_blink_ticks = COUNT_MAX;
        c.slow_blink_ticks = COUNT_MAX;
        c.arm_delay_ticks = COUNT_MAX;
      end
      2: begin
        // Zero threshold: never triggered, slow blink only
        c.trip_threshold = '0;
        c.fast_blink_ticks = 16'd1;
        c.slow_blink_ticks = CountW'($urandom_range(1, 3));
        c.arm_delay_ticks = '0;
      end
      4: begin
        c.fast_blink_ticks = CountW'($urandom_range(1, 3));
        c.slow_blink_ticks = CountW'($urandom_range(1, 3));
        c.arm_delay_ticks = CountW'($urandom_range(3));
      end
      5: begin
        c.fast_blink_ticks = CountW'($urandom_range(1, 20));
        c.slow_blink_ticks = CountW'($urandom_range(1, 20));
        c.arm_delay_ticks = CountW'($urandom_range(20, 80));
      end
      6: begin
        c.fast_blink_ticks = CountW'($urandom_range(1, 5));
        c.slow_blink_ticks = COUNT_MAX;
        c.arm_delay_ticks = CountW'($urandom_range(10));
      end
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    cfg_t        settings;
    int unsigned base;
    int unsigned span;
    int unsigned stop_at;
    tracker = new();
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_SAMPLE;
    in_ch.sample <= '0;

    // Hold reset, then release it once
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a tick with a full sample field (ignored), the average
    // climbing above the threshold on full-scale samples, then decaying back
    send_item(CMD_TICK, 12'hFFF);
    send_item(CMD_SAMPLE, 12'd4095);
    send_item(CMD_TICK, 12'd0);
    repeat (5) send_item(CMD_SAMPLE, 12'd4095);
    send_item(CMD_TICK, 12'hFFF);
    repeat (2) send_item(CMD_SAMPLE, 12'd0);
    send_item(CMD_TICK, 12'd0);
    settle();

    // Top threshold with zero blink period and zero arming delay: the first
    // triggered tick closes the relay and forces the indicator low
    apply_settings('{12'd4095, 16'd0, 16'd1, 16'd0});
    send_item(CMD_SAMPLE, 12'd4095);
    repeat (2) send_item(CMD_TICK, 12'h555);
    send_item(CMD_SAMPLE, 12'd0);
    settle();

    // Mid threshold: trigger and arm, then release above the threshold and
    // watch the slow blink toggle on every tick
    apply_settings('{12'd2000, 16'd0, 16'd1, 16'd0});
    repeat (3) send_item(CMD_SAMPLE, 12'd0);
    repeat (2) send_item(CMD_TICK, 12'hAAA);
    repeat (4) send_item(CMD_SAMPLE, 12'd4095);
    repeat (3) send_item(CMD_TICK, 12'd0);

    // Random phases: bursts of samples around a chosen level, each followed
    // by a random run of up to arm delay + 8 ticks (48 at most); some noise
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      settings = phase_settings(phase);
      settle();
      apply_settings(settings);
      stop_at = sent + ITEMS_PER_PHASE;
      while (sent < stop_at) begin
        if ($urandom_range(99) < 10) begin
          send_item(1'($urandom_range(1)), LevelW'($urandom));
        end else begin
          case ($urandom_range(2))
            0: base = $urandom_range(settings.trip_threshold);
            1: base = $urandom_range(4095, settings.trip_threshold);
            default: base = $urandom_range(4095);
          endcase
          repeat ($urandom_range(1, 5))
            if (sent < stop_at)
              send_item(CMD_SAMPLE, LevelW'(base ^ $urandom_range(63)));
          span = (settings.arm_delay_ticks < 40) ? settings.arm_delay_ticks + 8 : 48;
          repeat ($urandom_range(span))
            if (sent < stop_at) send_item(CMD_TICK, LevelW'($urandom));
        end
      end
    end

    // Drain everything still in flight, then give the verdict
    settle();
    if (tracker.mismatches == 0)
      $display("low_level_delayed_relay regression: pass");
    else
      $display("low_level_delayed_relay regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
hdl/lldr_pkg.sv
hdl/lldr_if.sv
hdl/lldr_update.sv
hdl/low_level_delayed_relay.sv
hdl/lldr_checker.sv
verif/tb.sv
